FILE: sv/dtms_pkg.sv
// shared constants and types of the dataflow token matching store
package dtms_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned MAX_OPERANDS  = 4;
  localparam int unsigned VALUE_BITS    = 32;

  localparam int unsigned IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int unsigned SLOT_W    = $clog2(MAX_OPERANDS);
  localparam int unsigned SLOT_AW   = IDX_W + SLOT_W;
  localparam int unsigned SLOT_DEPTH = TABLE_ENTRIES << SLOT_W;
  localparam int unsigned OP_LIMIT  = (MAX_OPERANDS < 4) ? MAX_OPERANDS : 4;

  typedef logic [VALUE_BITS-1:0] value_t;

  // one table entry as held in the entry memory
  typedef struct packed {
    logic [31:0]             key;
    logic [2:0]              count;
    logic [2:0]              needed;
    logic [15:0]             inst;
    logic [MAX_OPERANDS-1:0] mask;
  } entry_t;

  // write request to a memory
  typedef struct packed {
    logic        en;
    logic [IDX_W-1:0] addr;
    entry_t      data;
  } entry_wr_t;

endpackage

FILE: sv/dtms_entry_mem.sv
// entry memory: key, count, needed, address and slot mask per table entry
module dtms_entry_mem
  import dtms_pkg::*;
(
  input  logic             clk_i,
  input  entry_wr_t        wr_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output entry_t           rd_data_o
);

  entry_t mem [TABLE_ENTRIES];

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

FILE: sv/dtms_slot_mem.sv
// operand slot memory, addressed by entry and operand slot
module dtms_slot_mem
  import dtms_pkg::*;
(
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [SLOT_AW-1:0] wr_addr_i,
  input  value_t             wr_data_i,
  input  logic               rd_en_i,
  input  logic [SLOT_AW-1:0] rd_addr_i,
  output value_t             rd_data_o
);

  value_t mem [SLOT_DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

FILE: sv/dataflow_token_matching_store_core.sv
// top level of the dataflow token matching store
//
// Tokens arrive on the s_axis channel, one request per token. Operands leave
// on the m_axis channel, one request per operand; tlast marks the last
// operand of a fired group and tuser flags a dropped token (table full).
// Each token is looked up by a scan of the entry memory, one entry per cycle
// through its registered read port, so a token without a match passes every
// entry before the next is taken; a match ends the scan at its entry.
// A firing group then passes the update state (S_HIT) and, per operand,
// a slot memory read (S_EMIT_RD) and an output write (S_EMIT_WR), for up
// to four operands. Literal and single-input tokens without a match bypass
// the table after the scan; a literal sends its second operand from S_LIT2.
// Unfilled slots fire as zero through a per-entry written-slot mask, so no
// clearing pass is needed. Reset clears the valid bits and the control state
// at once. The result sits in an output register: while the receiver stalls
// the block finishes its scan and then waits with the next operand, holding
// s_axis_tready low until the token has been fully handled.
module dataflow_token_matching_store_core
  import dtms_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // token_id, port, token_value, inst_addr, needed_inputs, all_from_tokens,
  // has_literal, literal_port, literal_value, zero pad
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_token_id, out_inst_addr, out_port, out_value, zero pad
  output logic [87:0]  m_axis_tdata,
  // last_operand
  output logic         m_axis_tlast,
  // table_overflow
  output logic         m_axis_tuser
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN    = 7'b0000010,
    S_DECIDE  = 7'b0000100,
    S_LIT2    = 7'b0001000,
    S_HIT     = 7'b0010000,
    S_EMIT_RD = 7'b0100000,
    S_EMIT_WR = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // captured token
  logic [31:0] id_q;
  logic [1:0]  port_q;
  value_t      val_q;
  logic [15:0] inst_q;
  logic [2:0]  needed_q;
  logic        alltok_q, haslit_q;
  logic [1:0]  lport_q;
  value_t      lval_q;

  // scan state
  logic [IDX_W:0]   scan_idx_q, scan_idx_d;
  logic             cmp_q, cmp_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             free_fnd_q, free_fnd_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  entry_t           hit_q, hit_d;
  logic [2:0]       emit_q, emit_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;

  // output register
  logic        ovld_q, ovld_d;
  logic [31:0] oid_q, oid_d;
  logic [15:0] oinst_q, oinst_d;
  logic [1:0]  oport_q, oport_d;
  logic [31:0] oval_q, oval_d;
  logic        olast_q, olast_d, oovf_q, oovf_d;

  entry_wr_t        ent_wr;
  logic             ent_rd_en;
  logic [IDX_W-1:0] ent_rd_addr;
  entry_t           ent_rdata;
  logic             sl_wr_en, sl_rd_en;
  logic [SLOT_AW-1:0] sl_wr_addr, sl_rd_addr;
  value_t           sl_wr_data, sl_rdata;

  dtms_entry_mem u_entry (
    .clk_i     (clk_i),
    .wr_i      (ent_wr),
    .rd_en_i   (ent_rd_en),
    .rd_addr_i (ent_rd_addr),
    .rd_data_o (ent_rdata)
  );

  dtms_slot_mem u_slot (
    .clk_i     (clk_i),
    .wr_en_i   (sl_wr_en),
    .wr_addr_i (sl_wr_addr),
    .wr_data_i (sl_wr_data),
    .rd_en_i   (sl_rd_en),
    .rd_addr_i (sl_rd_addr),
    .rd_data_o (sl_rdata)
  );

  logic       out_free;
  logic       port_in;
  logic [2:0] open_need;
  logic [3:0] cnt_inc;
  logic       complete;
  logic [MAX_OPERANDS-1:0] port_bit;

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !ovld_q || m_axis_tready;
  assign port_in       = (32'(port_q) < MAX_OPERANDS);
  assign port_bit      = port_in ? (MAX_OPERANDS'(1) << port_q) : '0;
  assign cnt_inc       = {1'b0, hit_q.count} + 4'd1;
  assign complete      = (cnt_inc >= {1'b0, hit_q.needed});

  // needed count of a new entry: zero counts as one, clamped to the operand limit
  always_comb begin
    if (needed_q == 3'd0) begin
      open_need = 3'd1;
    end else if (32'(needed_q) > OP_LIMIT) begin
      open_need = 3'(OP_LIMIT);
    end else begin
      open_need = needed_q;
    end
  end

  // capture of an accepted token
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      id_q     <= s_axis_tdata[31:0];
      port_q   <= s_axis_tdata[33:32];
      val_q    <= VALUE_BITS'(s_axis_tdata[65:34]);
      inst_q   <= s_axis_tdata[81:66];
      needed_q <= s_axis_tdata[84:82];
      alltok_q <= s_axis_tdata[85];
      haslit_q <= s_axis_tdata[86];
      lport_q  <= s_axis_tdata[88:87];
      lval_q   <= VALUE_BITS'(s_axis_tdata[120:89]);
    end
  end

  // sequencer: scan, decide, update and emit
  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    cmp_d      = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    free_fnd_d = free_fnd_q;
    free_idx_d = free_idx_q;
    hit_idx_d  = hit_idx_q;
    hit_d      = hit_q;
    emit_d     = emit_q;
    valid_d    = valid_q;
    ovld_d     = ovld_q && !m_axis_tready;
    oid_d      = oid_q;
    oinst_d    = oinst_q;
    oport_d    = oport_q;
    oval_d     = oval_q;
    olast_d    = olast_q;
    oovf_d     = oovf_q;
    ent_wr     = '0;
    ent_rd_en  = 1'b0;
    ent_rd_addr = scan_idx_q[IDX_W-1:0];
    sl_wr_en   = 1'b0;
    sl_wr_addr = '0;
    sl_wr_data = val_q;
    sl_rd_en   = 1'b0;
    sl_rd_addr = {hit_idx_q, SLOT_W'(emit_q)};

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          scan_idx_d = '0;
          free_fnd_d = 1'b0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue the next read while comparing the previous one
        if (scan_idx_q < (IDX_W+1)'(TABLE_ENTRIES)) begin
          ent_rd_en  = 1'b1;
          cmp_d      = 1'b1;
          cmp_idx_d  = scan_idx_q[IDX_W-1:0];
          scan_idx_d = scan_idx_q + 1'b1;
        end
        if (cmp_q) begin
          if (valid_q[cmp_idx_q] && ent_rdata.key == id_q) begin
            hit_idx_d = cmp_idx_q;
            hit_d     = ent_rdata;
            cmp_d     = 1'b0;
            state_d   = S_HIT;
          end else begin
            if (!valid_q[cmp_idx_q] && !free_fnd_q) begin
              free_fnd_d = 1'b1;
              free_idx_d = cmp_idx_q;
            end
            if (cmp_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
              state_d = S_DECIDE;
            end
          end
        end
      end
      S_DECIDE: begin
        // header fields change only once the output register is free
        if (out_free) begin
          oid_d   = id_q;
          oinst_d = inst_q;
          oovf_d  = 1'b0;
        end
        priority if (alltok_q && needed_q == 3'd1) begin
          if (out_free) begin
            ovld_d  = 1'b1;
            oport_d = port_q;
            oval_d  = 32'(val_q);
            olast_d = 1'b1;
            state_d = S_IDLE;
          end
        end else if (haslit_q) begin
          if (out_free) begin
            ovld_d  = 1'b1;
            olast_d = 1'b0;
            if (lport_q < port_q) begin
              oport_d = lport_q;
              oval_d  = 32'(lval_q);
            end else begin
              oport_d = port_q;
              oval_d  = 32'(val_q);
            end
            state_d = S_LIT2;
          end
        end else if (!free_fnd_q) begin
          if (out_free) begin
            ovld_d  = 1'b1;
            oport_d = port_q;
            oval_d  = '0;
            olast_d = 1'b0;
            oovf_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          // open a new entry
          ent_wr.en          = 1'b1;
          ent_wr.addr        = free_idx_q;
          ent_wr.data.key    = id_q;
          ent_wr.data.count  = 3'd1;
          ent_wr.data.needed = open_need;
          ent_wr.data.inst   = inst_q;
          ent_wr.data.mask   = port_bit;
          sl_wr_en           = port_in;
          sl_wr_addr         = {free_idx_q, SLOT_W'(port_q)};
          valid_d[free_idx_q] = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_LIT2: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          olast_d = 1'b1;
          if (lport_q < port_q) begin
            oport_d = port_q;
            oval_d  = 32'(val_q);
          end else begin
            oport_d = lport_q;
            oval_d  = 32'(lval_q);
          end
          state_d = S_IDLE;
        end
      end
      S_HIT: begin
        // store the operand and update the entry
        sl_wr_en    = port_in;
        sl_wr_addr  = {hit_idx_q, SLOT_W'(port_q)};
        hit_d.mask  = hit_q.mask | port_bit;
        hit_d.count = cnt_inc[2:0];
        ent_wr.en   = 1'b1;
        ent_wr.addr = hit_idx_q;
        ent_wr.data = hit_d;
        if (complete) begin
          valid_d[hit_idx_q] = 1'b0;
          emit_d  = '0;
          state_d = S_EMIT_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        sl_rd_en = 1'b1;
        state_d  = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          oid_d   = id_q;
          oinst_d = hit_q.inst;
          oport_d = emit_q[1:0];
          oval_d  = hit_q.mask[SLOT_W'(emit_q)] ? 32'(sl_rdata) : '0;
          olast_d = (emit_q + 3'd1 == hit_q.needed);
          oovf_d  = 1'b0;
          emit_d  = emit_q + 3'd1;
          state_d = (emit_q + 3'd1 == hit_q.needed) ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      ovld_q  <= 1'b0;
      cmp_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      ovld_q  <= ovld_d;
      cmp_q   <= cmp_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    free_fnd_q <= free_fnd_d;
    free_idx_q <= free_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_q      <= hit_d;
    emit_q     <= emit_d;
    oid_q      <= oid_d;
    oinst_q    <= oinst_d;
    oport_q    <= oport_d;
    oval_q     <= oval_d;
    olast_q    <= olast_d;
    oovf_q     <= oovf_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {6'd0, oval_q, oport_q, oinst_q, oid_q};
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = oovf_q;

endmodule

FILE: dv/dataflow_token_matching_store_checker.sv
// checker of the token matching store: predicts fired operands and compares them
`timescale 1ns / 1ps

module dataflow_token_matching_store_checker
  import dtms_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [87:0]  m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic         m_axis_tuser,
  output int           errors_o,
  output int           pending_o
);

  // one expected operand
  typedef struct packed {
    logic [31:0] id;
    logic [15:0] inst;
    logic [1:0]  port;
    value_t      value;
    logic        last;
    logic        ovf;
  } operand_t;

  operand_t operand_q[$];

  // own copy of the match table
  logic        tbl_valid [TABLE_ENTRIES];
  logic [31:0] tbl_key   [TABLE_ENTRIES];
  logic [2:0]  tbl_count [TABLE_ENTRIES];
  logic [2:0]  tbl_need  [TABLE_ENTRIES];
  logic [15:0] tbl_inst  [TABLE_ENTRIES];
  value_t      tbl_slot  [TABLE_ENTRIES][MAX_OPERANDS];

  int errors;
  assign errors_o  = errors;
  assign pending_o = operand_q.size();

  function automatic operand_t mk_op(logic [31:0] id, logic [15:0] inst, logic [1:0] port,
                                     value_t value, logic last, logic ovf);
    operand_t o;
    o.id = id; o.inst = inst; o.port = port; o.value = value; o.last = last; o.ovf = ovf;
    return o;
  endfunction

  // match one token against the table and queue what it fires
  task automatic match_token(logic [127:0] d);
    logic [31:0] id;
    logic [1:0]  port, lport;
    value_t      val, lval;
    logic [15:0] inst;
    logic [2:0]  need_in, need;
    logic        aft, hl;
    int          hit, free_e;
    id = d[31:0]; port = d[33:32]; val = d[65:34]; inst = d[81:66];
    need_in = d[84:82]; aft = d[85]; hl = d[86]; lport = d[88:87]; lval = d[120:89];
    hit = -1; free_e = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        if (hit < 0 && tbl_key[i] == id) hit = i;
      end else if (free_e < 0) begin
        free_e = i;
      end
    end
    if (hit >= 0) begin
      if (port < MAX_OPERANDS) tbl_slot[hit][port] = val;
      if (tbl_count[hit] + 1 >= tbl_need[hit]) begin
        for (int p = 0; p < tbl_need[hit]; p++)
          operand_q.push_back(mk_op(id, tbl_inst[hit], p[1:0], tbl_slot[hit][p],
                                    p + 1 == tbl_need[hit], 1'b0));
        tbl_valid[hit] = 1'b0;
      end else begin
        tbl_count[hit] = tbl_count[hit] + 3'd1;
      end
    end else if (aft && need_in == 3'd1) begin
      operand_q.push_back(mk_op(id, inst, port, val, 1'b1, 1'b0));
    end else if (hl) begin
      if (lport < port) begin
        operand_q.push_back(mk_op(id, inst, lport, lval, 1'b0, 1'b0));
        operand_q.push_back(mk_op(id, inst, port, val, 1'b1, 1'b0));
      end else begin
        operand_q.push_back(mk_op(id, inst, port, val, 1'b0, 1'b0));
        operand_q.push_back(mk_op(id, inst, lport, lval, 1'b1, 1'b0));
      end
    end else if (free_e < 0) begin
      operand_q.push_back(mk_op(id, inst, port, '0, 1'b0, 1'b1));
    end else begin
      need = (need_in == 3'd0) ? 3'd1 : need_in;
      if (need > OP_LIMIT) need = 3'(OP_LIMIT);
      for (int s = 0; s < MAX_OPERANDS; s++) tbl_slot[free_e][s] = '0;
      if (port < MAX_OPERANDS) tbl_slot[free_e][port] = val;
      tbl_valid[free_e] = 1'b1;
      tbl_key[free_e]   = id;
      tbl_count[free_e] = 3'd1;
      tbl_need[free_e]  = need;
      tbl_inst[free_e]  = inst;
    end
  endtask

  initial begin
    errors = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
  end

  // watch both channels
  always @(posedge clk_i) begin
    operand_t got, exp_op;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) match_token(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got = mk_op(m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tdata[49:48],
                    m_axis_tdata[81:50], m_axis_tlast, m_axis_tuser);
        if (operand_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected operand %h", $realtime, got);
        end else begin
          exp_op = operand_q.pop_front();
          if (got.id !== exp_op.id)
            $display("%0t: token_id exp %h got %h", $realtime, exp_op.id, got.id);
          if (got.inst !== exp_op.inst)
            $display("%0t: inst_addr exp %h got %h", $realtime, exp_op.inst, got.inst);
          if (got.port !== exp_op.port)
            $display("%0t: port exp %h got %h", $realtime, exp_op.port, got.port);
          if (got.value !== exp_op.value)
            $display("%0t: value exp %h got %h", $realtime, exp_op.value, got.value);
          if (got.last !== exp_op.last)
            $display("%0t: last exp %b got %b", $realtime, exp_op.last, got.last);
          if (got.ovf !== exp_op.ovf)
            $display("%0t: overflow exp %b got %b", $realtime, exp_op.ovf, got.ovf);
          if (got !== exp_op) errors++;
        end
      end
    end
  end

endmodule

FILE: dv/dataflow_token_matching_store_core_test.sv
// stimulus and verdict for the dataflow token matching store
`timescale 1ns / 1ps

module dataflow_token_matching_store_core_test;
  import dtms_pkg::*;

  localparam int LIMIT = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         m_axis_tuser;
  int           errors, pending;
  int           cycles = 0;
  logic         hold_off = 1'b0;
  logic [127:0] batch_q[$];

  dataflow_token_matching_store_core uut (.*);

  dataflow_token_matching_store_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[dataflow_token_matching_store_core] ERROR");
      $finish;
    end
  end

  function automatic logic [127:0] tok(logic [31:0] id, logic [1:0] port, logic [31:0] val,
                                       logic [15:0] inst, logic [2:0] need, logic aft,
                                       logic hl, logic [1:0] lport, logic [31:0] lval);
    return {7'b0, lval, lport, hl, aft, need, inst, val, port, id};
  endfunction

  function automatic logic [127:0] noise_tok();
    return tok($urandom, 2'($urandom_range(0, 3)), $urandom, 16'($urandom_range(0, 65535)),
               3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               2'($urandom_range(0, 3)), $urandom);
  endfunction

  // offer one request and wait for it to be taken
  task automatic send(logic [127:0] d);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // one well-formed operand group in random port order
  task automatic add_group();
    logic [31:0] id;
    logic [15:0] inst;
    int          n, a, b;
    logic [1:0]  ports[4];
    id = $urandom; inst = 16'($urandom_range(0, 65535)); n = $urandom_range(2, 4);
    for (int i = 0; i < 4; i++) ports[i] = i[1:0];
    for (int i = 0; i < 4; i++) begin
      a = $urandom_range(0, 3); b = ports[a]; ports[a] = ports[i]; ports[i] = b[1:0];
    end
    for (int i = 0; i < n; i++)
      batch_q.push_back(tok(id, ports[i], $urandom, inst, n[2:0],
                            1'($urandom_range(0, 1)), 1'b0, 2'($urandom_range(0, 3)),
                            $urandom));
  endtask

  // receiver with random stalls and one long hold
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 3);
      if (hold_off) gap = 300;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        if (gap == 300) hold_off = 1'b0;
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  initial begin
    int a, r;
    logic [127:0] t;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send(tok(32'h0, 2'd0, 32'hFFFF_FFFF, 16'hFFFF, 3'd1, 1'b1, 1'b0, 2'd0, 32'h0));
    send(tok(32'hFFFF_FFFF, 2'd3, 32'h0, 16'h0, 3'd1, 1'b1, 1'b1, 2'd3, 32'hFFFF_FFFF));
    send(tok(32'h11, 2'd3, 32'hA5A5_0001, 16'h1234, 3'd2, 1'b0, 1'b1, 2'd1, 32'h5A5A));
    send(tok(32'h12, 2'd2, 32'h2, 16'h4321, 3'd3, 1'b0, 1'b1, 2'd2, 32'h3));
    send(tok(32'h13, 2'd0, 32'h4, 16'h0001, 3'd2, 1'b1, 1'b1, 2'd3, 32'h5));
    send(tok(32'h20, 2'd3, 32'hDEAD_BEEF, 16'h0020, 3'd3, 1'b0, 1'b0, 2'd0, 32'h0));
    send(tok(32'h20, 2'd3, 32'hCAFE_F00D, 16'h9999, 3'd1, 1'b1, 1'b1, 2'd0, 32'h7));
    send(tok(32'h20, 2'd1, 32'h1111, 16'h0, 3'd4, 1'b0, 1'b0, 2'd0, 32'h0));
    send(tok(32'h30, 2'd1, 32'h3030, 16'h0030, 3'd0, 1'b0, 1'b0, 2'd0, 32'h0));
    send(tok(32'h30, 2'd2, 32'h3131, 16'h0031, 3'd0, 1'b0, 1'b0, 2'd0, 32'h0));
    send(tok(32'h40, 2'd0, 32'h4000, 16'h0040, 3'd7, 1'b1, 1'b0, 2'd0, 32'h0));
    for (int i = 1; i < 4; i++)
      send(tok(32'h40, i[1:0], 32'h4000 + i, 16'h0, 3'd2, 1'b0, 1'b0, 2'd0, 32'h0));
    send(tok(32'h50, 2'd2, 32'h5050, 16'h0050, 3'd2, 1'b1, 1'b0, 2'd0, 32'h0));
    send(tok(32'h50, 2'd3, 32'h5151, 16'h0050, 3'd2, 1'b1, 1'b0, 2'd0, 32'h0));
    send(tok(32'h60, 2'd0, 32'h6060, 16'h0060, 3'd6, 1'b0, 1'b0, 2'd0, 32'h0));
    send(tok(32'h60, 2'd0, 32'h6161, 16'h0060, 3'd6, 1'b0, 1'b0, 2'd0, 32'h0));
    send(tok(32'h60, 2'd0, 32'h6262, 16'h0060, 3'd6, 1'b0, 1'b0, 2'd0, 32'h0));
    send(tok(32'h60, 2'd3, 32'h6363, 16'h0060, 3'd6, 1'b0, 1'b0, 2'd0, 32'h0));

    // sender pauses until everything has drained
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    // receiver holds off while literal tokens keep coming
    hold_off = 1'b1;
    for (int i = 0; i < 8; i++)
      send(tok($urandom, 2'($urandom_range(0, 3)), $urandom, 16'($urandom_range(0, 65535)),
               3'($urandom_range(2, 4)), 1'b0, 1'b1, 2'($urandom_range(0, 3)), $urandom));

    // fill the table, overflow it, then close every entry
    for (int i = 0; i < TABLE_ENTRIES + 3; i++)
      send(tok(32'h8000_0000 + i, 2'd0, $urandom, 16'($urandom_range(0, 65535)), 3'd2,
               1'b0, 1'b0, 2'd0, 32'h0));
    for (int i = 0; i < TABLE_ENTRIES; i++)
      send(tok(32'h8000_0000 + i, 2'd1, $urandom, 16'h0, 3'd2, 1'b0, 1'b0, 2'd0, 32'h0));

    // random part: interleaved groups with some noise
    for (int k = 0; k < 8; k++) begin
      r = $urandom_range(1, 3);
      for (int g = 0; g < r; g++) add_group();
      for (int i = 0; i < batch_q.size(); i++) begin
        a = $urandom_range(0, batch_q.size() - 1);
        t = batch_q[a]; batch_q[a] = batch_q[i]; batch_q[i] = t;
      end
      if ($urandom_range(0, 3) == 0) batch_q.push_back(noise_tok());
      while (batch_q.size() > 0) send(batch_q.pop_front());
    end

    // wait for drain and the tail latency
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[dataflow_token_matching_store_core] OK");
    end else begin
      $display("[dataflow_token_matching_store_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/dtms_pkg.sv
sv/dtms_entry_mem.sv
sv/dtms_slot_mem.sv
sv/dataflow_token_matching_store_core.sv
dv/dataflow_token_matching_store_checker.sv
dv/dataflow_token_matching_store_core_test.sv
